// ===== hw/rtl/sobpg_pkg.sv =====
// Shared constants and types of the Sobol point generator.
`timescale 1ns / 1ps
package sobpg_pkg;

	localparam int NUM_DIMS       = 64;
	localparam int NUM_DIRECTIONS = 32;
	localparam int WORD_W         = 32;
	localparam int DIR_W          = $clog2(NUM_DIRECTIONS);
	localparam int DIM_W          = $clog2(NUM_DIMS);
	localparam int ADDR_W         = DIM_W + DIR_W;
	localparam int TABLE_WORDS    = NUM_DIMS * NUM_DIRECTIONS;
	localparam int WIN_DEPTH      = NUM_DIRECTIONS - 1;
	localparam int COEF_W         = 30;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_GEN  = 1'b1;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic load;
		logic shift;
	} recur_ctrl_t;

endpackage

// ===== hw/rtl/sobpg_recur.sv =====
// Window of recent direction words and the Bratley-Fox recurrence for the next word.
`timescale 1ns / 1ps
module sobpg_recur (
	input  logic                                 clk,
	input  sobpg_pkg::recur_ctrl_t               ctrl,
	input  logic [4:0]                           degree,
	input  logic [sobpg_pkg::COEF_W-1:0]         coefficients,
	input  sobpg_pkg::word_t                     shift_word,
	output sobpg_pkg::word_t                     next_word
);
	import sobpg_pkg::*;

	word_t              win_q [WIN_DEPTH];
	logic [COEF_W-1:0]  mask_q;
	logic [COEF_W-1:0]  mask_d;
	logic [4:0]         deg_q;
	logic [4:0]         back_sel_q;

	always_comb begin
		logic [4:0] cidx;
		mask_d = '0;
		for (int t = 0; t < COEF_W; t++) begin
			cidx = degree - 5'(t) - 5'd2;
			if (({1'b0, 5'(t)} + 6'd2) <= {1'b0, degree}) begin
				mask_d[t] = coefficients[cidx];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			deg_q      <= degree;
			back_sel_q <= degree - 5'd1;
			mask_q     <= mask_d;
		end
		if (ctrl.shift) begin
			win_q[0] <= shift_word;
			for (int t = 1; t < WIN_DEPTH; t++) begin
				win_q[t] <= win_q[t-1];
			end
		end
	end

	always_comb begin
		word_t back;
		word_t acc;
		back = win_q[back_sel_q];
		acc  = back ^ (back >> deg_q);
		for (int t = 0; t < COEF_W; t++) begin
			if (mask_q[t]) begin
				acc = acc ^ win_q[t];
			end
		end
		next_word = acc;
	end

endmodule

// ===== hw/rtl/sobol_point_generator.sv =====
// Top level of the Sobol point generator with its direction word memory and sequencer.
//
// A word is accepted at a rising edge with start high and busy low. A load word
// (op 0) stores initial_m shifted to Q0.32 at the given position of a dimension;
// when position is degree-1 the block then reads positions 0..degree-1 back into
// a window and fills positions degree..31 by the XOR recurrence, one word a cycle.
// A generate word (op 1) walks the 32 direction words of the dimension through the
// single memory read port and XORs those selected by point_index.
// Every word gives exactly one result: done is high for one cycle with coordinate
// and status; the receiver cannot stall, so the result must be taken then.
// Short words (a rejected load, a load without expansion and any word for
// dimension 0) are answered from idle; long words (an expanding load and a
// generate) first walk the memory port in the read/expand or generate states.
// Busy drops in the cycle that shows the result, so short words follow back to
// back and a long word holds off new words until its result is shown.
// Reset clears the sequencer and the result strobe only; the memory is not
// cleared, and a dimension must be loaded completely before it is used.
`timescale 1ns / 1ps
module sobol_point_generator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         op,
	input  logic [5:0]                   dimension,
	input  logic [4:0]                   degree,
	input  logic [sobpg_pkg::COEF_W-1:0] coefficients,
	input  logic [4:0]                   position,
	input  logic [30:0]                  initial_m,
	input  logic [31:0]                  point_index,
	output logic                         done,
	output logic [31:0]                  coordinate,
	output logic                         status
);
	import sobpg_pkg::*;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_READ    = 3'd1;
	localparam logic [2:0] ST_EXPAND  = 3'd2;
	localparam logic [2:0] ST_GEN     = 3'd3;
	localparam logic [2:0] ST_GEN_END = 3'd4;

	logic [2:0]        state_q;
	logic [DIR_W-1:0]  cnt_q;
	logic [DIR_W-1:0]  last_q;
	logic [DIM_W-1:0]  dim_q;
	logic [31:0]       idx_q;
	word_t             acc_q;
	logic              rd_vld_s1;
	logic              bit_s1;
	word_t             rd_q;
	logic              done_q;
	word_t             coord_q;
	logic              status_q;

	word_t             mem_q [TABLE_WORDS];
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	word_t             mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic              rd_en;

	logic              accept;
	logic              dim_ok;
	logic              load_bad;
	word_t             load_word;
	word_t             rev_index;
	recur_ctrl_t       rctrl;
	word_t             shift_word;
	word_t             next_word;

	assign accept    = start && !busy;
	assign dim_ok    = int'(dimension) < NUM_DIMS;
	assign load_bad  = (dimension == 6'd0) || (position >= degree);
	assign load_word = word_t'({1'b0, initial_m} << (5'd31 - position));

	always_comb begin
		for (int k = 0; k < WORD_W; k++) begin
			rev_index[WORD_W-1-k] = point_index[k];
		end
	end

	assign busy       = state_q != ST_IDLE;
	assign done       = done_q;
	assign coordinate = coord_q;
	assign status     = status_q;

	assign rd_en     = (state_q == ST_READ) || (state_q == ST_GEN);
	assign mem_raddr = {dim_q, cnt_q};

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = {DIM_W'(dimension), position};
		mem_wdata = load_word;
		if (accept && dim_ok && op == OP_LOAD && !load_bad) begin
			mem_we = 1'b1;
		end else if (state_q == ST_EXPAND && !rd_vld_s1) begin
			mem_we    = 1'b1;
			mem_waddr = {dim_q, cnt_q};
			mem_wdata = next_word;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem_q[mem_raddr];
	end

	assign rctrl.load  = accept;
	assign rctrl.shift = (state_q == ST_READ && rd_vld_s1) || (state_q == ST_EXPAND);
	assign shift_word  = rd_vld_s1 ? rd_q : next_word;

	sobpg_recur u_recur (
		.clk          (clk),
		.ctrl         (rctrl),
		.degree       (degree),
		.coefficients (coefficients),
		.shift_word   (shift_word),
		.next_word    (next_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			done_q    <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (!dim_ok) begin
							done_q <= 1'b1;
						end else if (op == OP_LOAD) begin
							if (load_bad || position != degree - 5'd1) begin
								done_q <= 1'b1;
							end else begin
								state_q <= ST_READ;
							end
						end else if (dimension == 6'd0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_GEN;
						end
					end
				end
				ST_READ: begin
					if (cnt_q == last_q) begin
						cnt_q   <= last_q + 5'd1;
						state_q <= ST_EXPAND;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_EXPAND: begin
					if (!rd_vld_s1) begin
						if (cnt_q == DIR_W'(NUM_DIRECTIONS - 1)) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + 5'd1;
						end
					end
				end
				ST_GEN: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == DIR_W'(NUM_DIRECTIONS - 1)) begin
						state_q <= ST_GEN_END;
					end
				end
				ST_GEN_END: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		bit_s1 <= idx_q[0];
		if (accept) begin
			dim_q  <= DIM_W'(dimension);
			last_q <= degree - 5'd1;
			idx_q  <= point_index;
			acc_q  <= '0;
		end else begin
			if (state_q == ST_GEN) begin
				idx_q <= idx_q >> 1;
			end
			if (rd_vld_s1 && bit_s1 && (state_q == ST_GEN || state_q == ST_GEN_END)) begin
				acc_q <= acc_q ^ rd_q;
			end
		end
		if (accept) begin
			coord_q  <= '0;
			status_q <= STATUS_OK;
			if (!dim_ok || (op == OP_LOAD && load_bad)) begin
				status_q <= STATUS_REJECT;
			end else if (op == OP_GEN && dimension == 6'd0) begin
				coord_q <= rev_index;
			end
		end else if (state_q == ST_GEN_END) begin
			coord_q <= acc_q ^ ((rd_vld_s1 && bit_s1) ? rd_q : '0);
		end
	end

`ifndef ASSERT_OFF
	a_accept_answered: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy || done)
		else $error("accepted word neither in work nor answered");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while the sequencer is still busy");
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STATUS_REJECT |-> coordinate == '0)
		else $error("rejected word carries a nonzero coordinate");
	a_gen_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GEN || state_q == ST_GEN_END |-> !mem_we)
		else $error("memory written during point generation");
	a_read_source: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q) == ST_READ || $past(state_q) == ST_GEN)
		else $error("read data flagged without a preceding read");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench that predicts every result word of the Sobol point generator.
`timescale 1ns / 1ps
module testbench;
	import sobpg_pkg::*;

	class coordinate_scoreboard;
		typedef struct packed {
			logic [WORD_W-1:0] coordinate;
			logic              status;
		} coord_word_t;

		bit [WORD_W-1:0] dir_words [NUM_DIMS][NUM_DIRECTIONS];
		coord_word_t     expected_coords [$];
		int              mismatches;
		int              loads;
		int              expansions;
		int              rejects;
		int              generates;

		function void expand_dimension(int dim, int deg, logic [COEF_W-1:0] coeff);
			bit [WORD_W-1:0] back;
			bit [WORD_W-1:0] acc;
			for (int i = deg; i < NUM_DIRECTIONS; i++) begin
				back = dir_words[dim][i - deg];
				acc = back ^ (back >> deg);
				for (int j = 1; j < deg; j++) begin
					if (coeff[deg - 1 - j]) begin
						acc ^= dir_words[dim][i - j];
					end
				end
				dir_words[dim][i] = acc;
			end
		endfunction

		function void note_word(logic w_op, logic [5:0] w_dim, logic [4:0] w_deg,
				logic [COEF_W-1:0] w_coeff, logic [4:0] w_pos, logic [30:0] w_m,
				logic [31:0] w_idx);
			coord_word_t exp_word;
			exp_word.coordinate = '0;
			exp_word.status = STATUS_OK;
			if (w_dim >= NUM_DIMS) begin
				exp_word.status = STATUS_REJECT;
			end else if (w_op == OP_LOAD) begin
				loads++;
				if (w_dim == 0 || w_pos >= w_deg) begin
					exp_word.status = STATUS_REJECT;
					rejects++;
				end else begin
					dir_words[w_dim][w_pos] = WORD_W'(64'(w_m) << (31 - w_pos));
					if (w_pos == w_deg - 1) begin
						expand_dimension(w_dim, w_deg, w_coeff);
						expansions++;
					end
				end
			end else begin
				generates++;
				for (int k = 0; k < NUM_DIRECTIONS; k++) begin
					if (w_idx[k]) begin
						if (w_dim == 0) begin
							exp_word.coordinate ^= 32'h8000_0000 >> k;
						end else begin
							exp_word.coordinate ^= dir_words[w_dim][k];
						end
					end
				end
			end
			expected_coords.push_back(exp_word);
		endfunction

		task report_mismatch(string what);
			$display("MISMATCH at %0t ns: %s", $time, what);
			mismatches++;
		endtask

		task check_word(logic [WORD_W-1:0] got_coord, logic got_status);
			coord_word_t exp_word;
			if (expected_coords.size() == 0) begin
				report_mismatch($sformatf("result word %h/%b with no word outstanding",
					got_coord, got_status));
			end else begin
				exp_word = expected_coords.pop_front();
				if (got_coord !== exp_word.coordinate) begin
					report_mismatch($sformatf("coordinate %h, predicted %h",
						got_coord, exp_word.coordinate));
				end
				if (got_status !== exp_word.status) begin
					report_mismatch($sformatf("status %b, predicted %b",
						got_status, exp_word.status));
				end
			end
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                op;
	logic [5:0]          dimension;
	logic [4:0]          degree;
	logic [COEF_W-1:0]   coefficients;
	logic [4:0]          position;
	logic [30:0]         initial_m;
	logic [31:0]         point_index;
	logic                done;
	logic [31:0]         coordinate;
	logic                status;

	coordinate_scoreboard       coord_board;
	bit [NUM_DIRECTIONS-1:0]    written_mask [NUM_DIMS];
	int                         sender_idle_pct;
	int                         words_sent;
	int                         phase_end;

	sobol_point_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.dimension    (dimension),
		.degree       (degree),
		.coefficients (coefficients),
		.position     (position),
		.initial_m    (initial_m),
		.point_index  (point_index),
		.done         (done),
		.coordinate   (coordinate),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			coord_board.check_word(coordinate, status);
		end
	end

	function automatic bit dim_ready(int dim);
		return dim == 0 || written_mask[dim] == '1;
	endfunction

	function automatic logic [31:0] rand_index();
		case ($urandom_range(3))
			0: return $urandom_range(255);
			1: return 32'd1 << $urandom_range(31);
			2: return $urandom | $urandom;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(input logic w_op, input logic [5:0] w_dim,
			input logic [4:0] w_deg, input logic [COEF_W-1:0] w_coeff,
			input logic [4:0] w_pos, input logic [30:0] w_m, input logic [31:0] w_idx);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		op <= w_op;
		dimension <= w_dim;
		degree <= w_deg;
		coefficients <= w_coeff;
		position <= w_pos;
		initial_m <= w_m;
		point_index <= w_idx;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		coord_board.note_word(w_op, w_dim, w_deg, w_coeff, w_pos, w_m, w_idx);
		words_sent++;
		if (w_op == OP_LOAD && w_dim != 0 && w_pos < w_deg) begin
			written_mask[w_dim][w_pos] = 1'b1;
			if (w_pos == w_deg - 1) begin
				for (int k = w_deg; k < NUM_DIRECTIONS; k++) begin
					written_mask[w_dim][k] = 1'b1;
				end
			end
		end
	endtask

	task automatic send_load(int dim, int deg, int coeff, int pos, int m);
		send_word(OP_LOAD, 6'(dim), 5'(deg), COEF_W'(coeff), 5'(pos), 31'(m), $urandom);
	endtask

	task automatic send_gen(int dim, logic [31:0] idx);
		send_word(OP_GEN, 6'(dim), 5'($urandom), COEF_W'($urandom), 5'($urandom),
			31'($urandom), idx);
	endtask

	task automatic wait_until_drained();
		if (coord_board.expected_coords.size() != 0) begin
			start <= 1'b0;
			while (coord_board.expected_coords.size() != 0) @(posedge clk);
		end
	endtask

	// The position degree-1 goes last so that the expansion only reads written words.
	task automatic load_dimension(int dim, int deg);
		int order [NUM_DIRECTIONS];
		int coeff;
		int pick;
		int tmp;
		coeff = $urandom;
		for (int i = 0; i < deg - 1; i++) begin
			order[i] = i;
		end
		for (int i = deg - 2; i > 0; i--) begin
			pick = $urandom_range(i);
			tmp = order[i];
			order[i] = order[pick];
			order[pick] = tmp;
		end
		for (int i = 0; i < deg - 1; i++) begin
			send_load(dim, deg, coeff, order[i], $urandom);
		end
		send_load(dim, deg, coeff, deg - 1, $urandom);
	endtask

	task automatic run_random_step();
		int kind;
		int dim;
		int deg;
		int pos;
		int tries;
		kind = $urandom_range(99);
		if (kind < 55) begin
			dim = $urandom_range(63, 1);
			deg = ($urandom_range(9) == 0) ? $urandom_range(31, 9) : $urandom_range(8, 1);
			load_dimension(dim, deg);
			repeat ($urandom_range(4, 1)) send_gen(dim, rand_index());
		end else if (kind < 75) begin
			dim = $urandom_range(63);
			tries = 0;
			while (!dim_ready(dim) && tries < 8) begin
				dim = $urandom_range(63);
				tries++;
			end
			if (!dim_ready(dim)) begin
				dim = 0;
			end
			send_gen(dim, rand_index());
		end else if (kind < 88) begin
			if ($urandom_range(1) == 0) begin
				send_load(0, $urandom_range(31), $urandom, $urandom_range(31), $urandom);
			end else begin
				deg = $urandom_range(31);
				pos = $urandom_range(31, deg);
				send_load($urandom_range(63), deg, $urandom, pos, $urandom);
			end
		end else if (kind < 97) begin
			pos = $urandom_range(29);
			deg = $urandom_range(31, pos + 2);
			send_load($urandom_range(63, 1), deg, $urandom, pos, $urandom);
		end else begin
			wait_until_drained();
		end
	endtask

	initial begin
		coord_board = new();
		words_sent = 0;
		sender_idle_pct = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		op <= OP_LOAD;
		dimension <= '0;
		degree <= '0;
		coefficients <= '0;
		position <= '0;
		initial_m <= '0;
		point_index <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gen(0, 32'h0000_0000);
		send_gen(0, 32'hFFFF_FFFF);
		send_gen(0, 32'h0000_0001);
		send_gen(0, 32'h8000_0000);
		send_load(0, 5, 30'h3FFF_FFFF, 0, 1);
		send_load(7, 0, 0, 0, 1);
		send_load(7, 31, 30'h3FFF_FFFF, 31, 31'h7FFF_FFFF);
		send_load(7, 3, 1, 3, 3);
		send_load(1, 1, 30'h3FFF_FFFF, 0, 1);
		send_gen(1, 32'h0000_0000);
		send_gen(1, 32'hFFFF_FFFF);
		send_gen(1, 32'h0000_0003);
		send_load(62, 3, 30'h3FFF_FFFF, 1, 1);
		send_load(62, 3, 30'h3FFF_FFFF, 0, 31'h7FFF_FFFF);
		send_load(62, 3, 30'h3FFF_FFFF, 2, 5);
		send_load(62, 3, 0, 0, 3);
		send_gen(62, 32'hFFFF_FFFF);
		send_gen(62, 32'h5555_5555);
		send_load(63, 2, 0, 0, 31'h7FFF_FFFF);
		send_load(63, 2, 0, 1, 0);
		send_gen(63, 32'hAAAA_AAAA);
		send_gen(63, 32'h0000_0000);
		wait_until_drained();

		for (int phase = 0; phase < 3; phase++) begin
			sender_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 86 : 0;
			phase_end = words_sent + 270;
			while (words_sent < phase_end) begin
				run_random_step();
			end
			wait_until_drained();
		end
		repeat (40) @(posedge clk);

		$display("Covered %0d load words (%0d expansions, %0d rejected) and %0d generate words.",
			coord_board.loads, coord_board.expansions, coord_board.rejects,
			coord_board.generates);
		$display("Sender idle rates were 26, 86 and 0 percent, with full drains in between.");
		if (coord_board.mismatches == 0 && coord_board.expected_coords.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// ===== files.f =====
hw/rtl/sobpg_pkg.sv
hw/rtl/sobpg_recur.sv
hw/rtl/sobol_point_generator.sv
sim/testbench.sv
